// ===== sv/pid_controller_clamped_macros.svh =====
// Assertion macros used by the checker file of the PID controller.
// All macros sample on the rising edge of clock.
`ifndef PID_CONTROLLER_CLAMPED_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_MACROS_SVH

// Checked only while reset is low.
`define PIDC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define PIDC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/pidc_pkg.sv =====
// Package of the clamped PID controller: widths, item and gain types, limits.
// Used by pidc_front, pidc_back and pid_controller_clamped; depends on nothing.
`timescale 1ns / 1ps

package pidc_pkg;

   localparam int ErrW       = 16;
   localparam int TimeW      = 16;
   localparam int GainW      = 16;
   localparam int DriveW     = 16;
   localparam int IntegW     = 48;
   localparam int AccW       = 64;
   localparam int EdW        = ErrW + TimeW + 1;
   localparam int DiffW      = ErrW + 1;
   localparam int DerivShift = 10;
   localparam int DivNumW    = ErrW + DerivShift;
   localparam int DivSteps   = DivNumW;
   localparam int DivCntW    = $clog2(DivSteps);
   localparam int DerivW     = DivNumW + 1;
   localparam int MulOpW     = 29;
   localparam int ProdW      = GainW + MulOpW;
   localparam int IntegHalfW = IntegW / 2;
   localparam int MulPhases  = 4;
   localparam int PhaseW     = $clog2(MulPhases + 1);
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);
   localparam int CsrIndexW  = 2;

   localparam logic signed [IntegW-1:0] IntegMax = {1'b0, {(IntegW-1){1'b1}}};
   localparam logic signed [IntegW-1:0] IntegMin = {1'b1, {(IntegW-1){1'b0}}};
   localparam logic signed [AccW-1:0]   UnitOne    = 64'sd1073741824;
   localparam logic signed [AccW-1:0]   UnitOneNeg = -64'sd1073741824;
   localparam logic signed [DriveW-1:0] DrivePos   = 16'sd16384;
   localparam logic signed [DriveW-1:0] DriveNeg   = -16'sd16384;
   localparam logic signed [GainW-1:0]  GainPReset = 16'sd256;
   localparam logic signed [GainW-1:0]  GainZero   = 16'sd0;

   typedef enum logic {
      OP_STEP  = 1'b0,
      OP_CLEAR = 1'b1
   } pidc_op_type;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_GAIN_P = 2'd0,
      CSR_GAIN_I = 2'd1,
      CSR_GAIN_D = 2'd2
   } pidc_csr_type;

   typedef struct packed {
      pidc_op_type              op;
      logic signed [ErrW-1:0]   error_sample;
      logic [TimeW-1:0]         step_time;
   } pidc_item_type;

   typedef struct packed {
      logic signed [GainW-1:0] proportional;
      logic signed [GainW-1:0] integral;
      logic signed [GainW-1:0] derivative;
   } pidc_gains_type;

endpackage

// ===== sv/pidc_front.sv =====
// Front part of the PID controller: takes request beats, decodes the opcode
// and holds items in a short queue for the back part. Uses pidc_pkg.
`timescale 1ns / 1ps

module pidc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,   // error_sample [15:0], step_time [31:16]
   input  logic [0:0]             req_tuser,   // opcode [0]
   output logic                   item_valid,
   output pidc_pkg::pidc_item_type item,
   input  logic                   item_pop
);

   pidc_pkg::pidc_item_type              queue_ff [pidc_pkg::QueueDepth];
   logic [pidc_pkg::QueuePtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [pidc_pkg::QueuePtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [pidc_pkg::QueueCntW-1:0]       count_ff, count_in;
   pidc_pkg::pidc_item_type              entry_in;
   logic                                 push;
   logic                                 pop;

   assign req_tready = count_ff != pidc_pkg::QueueCntW'(pidc_pkg::QueueDepth);
   assign push       = req_tvalid && req_tready;
   assign item_valid = count_ff != '0;
   assign pop        = item_pop && item_valid;
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      entry_in.op           = req_tuser[0] ? pidc_pkg::OP_CLEAR : pidc_pkg::OP_STEP;
      entry_in.error_sample = req_tdata[15:0];
      entry_in.step_time    = req_tdata[31:16];
      wr_ptr_in = (wr_ptr_ff == pidc_pkg::QueuePtrW'(pidc_pkg::QueueDepth - 1)) ?
                  '0 : wr_ptr_ff + 1'b1;
      rd_ptr_in = (rd_ptr_ff == pidc_pkg::QueuePtrW'(pidc_pkg::QueueDepth - 1)) ?
                  '0 : rd_ptr_ff + 1'b1;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

// ===== sv/pidc_back.sv =====
// Back part of the PID controller: keeps the error state, runs the bit-serial
// divider and the shared multiply-accumulate, clamps and registers the result.
// Uses pidc_pkg.
`timescale 1ns / 1ps

module pidc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  pidc_pkg::pidc_item_type  item,
   output logic                     item_pop,
   input  pidc_pkg::pidc_gains_type gains,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,   // drive [15:0]
   output logic [0:0]               rsp_tuser    // clamped [0]
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INTEG,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      SH_NONE,
      SH_DERIV,
      SH_HIGH
   } shift_type;

   state_type                                  state_ff;
   logic signed [pidc_pkg::ErrW-1:0]           last_error_ff;
   logic signed [pidc_pkg::IntegW-1:0]         integ_ff, integ_in;
   logic signed [pidc_pkg::ErrW-1:0]           err_ff;
   logic [pidc_pkg::TimeW-1:0]                 dt_ff;
   logic signed [pidc_pkg::EdW-1:0]            ed_ff, ed_in;
   logic [pidc_pkg::DivNumW-1:0]               div_ff, div_in;
   logic [pidc_pkg::TimeW-1:0]                 rem_ff, rem_in;
   logic                                       neg_ff;
   logic [pidc_pkg::DivCntW-1:0]               cnt_ff;
   logic signed [pidc_pkg::DerivW-1:0]         deriv_ff, deriv_in;
   logic [pidc_pkg::PhaseW-1:0]                phase_ff;
   logic signed [pidc_pkg::ProdW-1:0]          prod_ff, prod_in;
   shift_type                                  shift_ff, shift_in;
   logic signed [pidc_pkg::AccW-1:0]           acc_ff, acc_in;
   logic                                       rsp_valid_ff;
   logic signed [pidc_pkg::DriveW-1:0]         drive_ff, drive_in;
   logic                                       clamp_ff, clamp_in;

   logic signed [pidc_pkg::DiffW-1:0]          diff;
   logic [pidc_pkg::DiffW-1:0]                 diff_mag;
   logic signed [pidc_pkg::IntegW:0]           integ_sum;
   logic [pidc_pkg::TimeW:0]                   rem_shift;
   logic [pidc_pkg::TimeW:0]                   trial;
   logic                                       quo_bit;
   logic signed [pidc_pkg::GainW-1:0]          mul_gain;
   logic signed [pidc_pkg::MulOpW-1:0]         mul_op;
   logic signed [pidc_pkg::AccW-1:0]           prod_ext;
   logic                                       out_free;

   assign item_pop   = (state_ff == ST_IDLE) && item_valid;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = drive_ff;
   assign rsp_tuser  = clamp_ff;

   always_comb begin
      diff     = pidc_pkg::DiffW'(item.error_sample) - pidc_pkg::DiffW'(last_error_ff);
      diff_mag = diff[pidc_pkg::DiffW-1] ? pidc_pkg::DiffW'(-diff) : pidc_pkg::DiffW'(diff);
      ed_in    = $signed(item.error_sample) * $signed({1'b0, item.step_time});

      integ_sum = pidc_pkg::IntegW'(integ_ff) + (pidc_pkg::IntegW + 1)'(ed_ff);
      if (integ_sum[pidc_pkg::IntegW] != integ_sum[pidc_pkg::IntegW-1]) begin
         integ_in = integ_sum[pidc_pkg::IntegW] ? pidc_pkg::IntegMin : pidc_pkg::IntegMax;
      end else begin
         integ_in = integ_sum[pidc_pkg::IntegW-1:0];
      end

      rem_shift = {rem_ff, div_ff[pidc_pkg::DivNumW-1]};
      trial     = rem_shift - {1'b0, dt_ff};
      quo_bit   = !trial[pidc_pkg::TimeW];
      rem_in    = quo_bit ? trial[pidc_pkg::TimeW-1:0] : rem_shift[pidc_pkg::TimeW-1:0];
      div_in    = {div_ff[pidc_pkg::DivNumW-2:0], quo_bit};

      if (dt_ff == '0) begin
         deriv_in = '0;
      end else if (neg_ff) begin
         deriv_in = -$signed({1'b0, div_ff});
      end else begin
         deriv_in = $signed({1'b0, div_ff});
      end

      case (phase_ff)
         3'd0: begin
            mul_gain = gains.proportional;
            mul_op   = pidc_pkg::MulOpW'(err_ff);
            shift_in = SH_DERIV;
         end
         3'd1: begin
            mul_gain = gains.derivative;
            mul_op   = pidc_pkg::MulOpW'(deriv_ff);
            shift_in = SH_DERIV;
         end
         3'd2: begin
            mul_gain = gains.integral;
            mul_op   = $signed({{(pidc_pkg::MulOpW - pidc_pkg::IntegHalfW){1'b0}},
                                integ_ff[pidc_pkg::IntegHalfW-1:0]});
            shift_in = SH_NONE;
         end
         default: begin
            mul_gain = gains.integral;
            mul_op   = pidc_pkg::MulOpW'(
                          $signed(integ_ff[pidc_pkg::IntegW-1:pidc_pkg::IntegHalfW]));
            shift_in = SH_HIGH;
         end
      endcase
      prod_in = mul_gain * mul_op;

      prod_ext = pidc_pkg::AccW'(prod_ff);
      case (shift_ff)
         SH_DERIV: acc_in = acc_ff + (prod_ext <<< pidc_pkg::DerivShift);
         SH_HIGH:  acc_in = acc_ff + (prod_ext <<< pidc_pkg::IntegHalfW);
         default:  acc_in = acc_ff + prod_ext;
      endcase

      if (acc_ff > pidc_pkg::UnitOne) begin
         drive_in = pidc_pkg::DrivePos;
         clamp_in = 1'b1;
      end else if (acc_ff < pidc_pkg::UnitOneNeg) begin
         drive_in = pidc_pkg::DriveNeg;
         clamp_in = 1'b1;
      end else begin
         drive_in = acc_ff[pidc_pkg::DriveW+15:16];
         clamp_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         last_error_ff <= '0;
         integ_ff      <= '0;
         phase_ff      <= '0;
         cnt_ff        <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (item_valid) begin
                  acc_ff <= '0;
                  if (item.op == pidc_pkg::OP_CLEAR) begin
                     last_error_ff <= '0;
                     integ_ff      <= '0;
                     state_ff      <= ST_DONE;
                  end else begin
                     err_ff        <= item.error_sample;
                     dt_ff         <= item.step_time;
                     last_error_ff <= item.error_sample;
                     ed_ff         <= ed_in;
                     neg_ff        <= diff[pidc_pkg::DiffW-1];
                     div_ff        <= {diff_mag[pidc_pkg::ErrW-1:0],
                                       {pidc_pkg::DerivShift{1'b0}}};
                     rem_ff        <= '0;
                     cnt_ff        <= pidc_pkg::DivCntW'(pidc_pkg::DivSteps - 1);
                     state_ff      <= ST_INTEG;
                  end
               end
            end
            ST_INTEG: begin
               integ_ff <= integ_in;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               div_ff <= div_in;
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  phase_ff <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (phase_ff == '0) begin
                  deriv_ff <= deriv_in;
               end else begin
                  acc_ff <= acc_in;
               end
               prod_ff  <= prod_in;
               shift_ff <= shift_in;
               phase_ff <= phase_ff + 1'b1;
               if (phase_ff == pidc_pkg::PhaseW'(pidc_pkg::MulPhases)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  drive_ff     <= drive_in;
                  clamp_ff     <= clamp_in;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== sv/pid_controller_clamped.sv =====
// Top level of the clamped PID controller: gain registers, front and back parts.
// Depends on pidc_pkg, pidc_front and pidc_back.
//
// Each request beat is a control step or a clear. A step takes the item
// from the queue, updates the saturating integral, runs the bit-serial
// division of the error difference by the step time, uses the shared 16 by
// 29 bit multiplier and its accumulator, and clamps and registers the
// result. A clear goes from the queue straight to the result register.
// The divider and the single multiplier set the length of a step.
// A two-entry queue takes new beats while the back part works, and the
// result register holds a finished beat while the next item is computed.
// Gains are written through the csr port and read as a step multiplies.
`timescale 1ns / 1ps

module pid_controller_clamped (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // error_sample [15:0], step_time [31:16]
   input  logic [0:0]  req_tuser,   // opcode [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // drive [15:0]
   output logic [0:0]  rsp_tuser,   // clamped [0]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   pidc_pkg::pidc_gains_type gains_ff;
   pidc_pkg::pidc_item_type  item;
   logic                     item_valid;
   logic                     item_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.proportional <= pidc_pkg::GainPReset;
         gains_ff.integral     <= pidc_pkg::GainZero;
         gains_ff.derivative   <= pidc_pkg::GainZero;
      end else if (csr_we) begin
         case (csr_index)
            pidc_pkg::CSR_GAIN_P: gains_ff.proportional <= csr_wdata;
            pidc_pkg::CSR_GAIN_I: gains_ff.integral     <= csr_wdata;
            pidc_pkg::CSR_GAIN_D: gains_ff.derivative   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   pidc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   pidc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .gains      (gains_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== sv/pidc_checker.sv =====
// Port-level checks of the clamped PID controller, bound to the top level.
// Depends on pid_controller_clamped_macros.svh.
`timescale 1ns / 1ps
`include "pid_controller_clamped_macros.svh"

module pidc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   `PIDC_ASSERT_ALWAYS(a_reset_state, reset |=> (req_tready && !rsp_tvalid), "bad state after reset")
   `PIDC_ASSERT(a_rsp_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)), "stalled result beat changed")
   `PIDC_ASSERT(a_clamp_value, (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == 16'h4000 || rsp_tdata == 16'hC000), "clamped beat not at a limit")
   `PIDC_ASSERT(a_drive_range, rsp_tvalid |-> ($signed(rsp_tdata) <= 16'sd16384 && $signed(rsp_tdata) >= -16'sd16384), "drive beyond one")

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== verif/tb_pid_controller_clamped.sv =====
// Self-checking testbench for pid_controller_clamped: directed and random step and clear
// beats under several gain settings, with a PID predictor checking every result beat.
// Depends on pidc_pkg and the pid_controller_clamped RTL.
`timescale 1ns / 1ps

module tb_pid_controller_clamped;

   localparam int ClockPeriod  = 8;
   localparam int ResetCycles  = 10;
   localparam longint CycleLimit = 1000000;
   localparam int SettleCycles = 4;
   localparam int DrainCycles  = 60;
   localparam int ReportLimit  = 10;
   localparam int RandomPhases = 8;
   localparam int PhaseItems   = 200;
   localparam int HoldCycles   = 600;
   localparam logic [pidc_pkg::CsrIndexW-1:0] CsrUnused = 2'd3;

   typedef struct packed {
      logic signed [pidc_pkg::DriveW-1:0] drive;
      logic                               clamped;
   } drive_beat_type;

   typedef enum int {
      READY_ALWAYS,
      READY_HALF,
      READY_SPARSE,
      READY_PERIODIC
   } ready_pattern_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   pidc_pkg::pidc_item_type pending_items[$];
   drive_beat_type          expected_drives[$];

   logic signed [pidc_pkg::GainW-1:0] kp = pidc_pkg::GainPReset;
   logic signed [pidc_pkg::GainW-1:0] ki = pidc_pkg::GainZero;
   logic signed [pidc_pkg::GainW-1:0] kd = pidc_pkg::GainZero;
   longint held_error = 0;
   longint integral = 0;

   int     accepted_items = 0;
   int     mismatches = 0;
   int     gap_max = 0;
   int     burst_left = 0;
   int     gap_left = 0;
   int     mode_left = 0;
   int     hold_left = 0;
   int     holds_done = 0;
   longint cycles = 0;
   ready_pattern_type ready_pattern = READY_ALWAYS;

   pid_controller_clamped u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   function automatic drive_beat_type pid_step(pidc_pkg::pidc_item_type it);
      longint err;
      longint dt;
      longint deriv;
      longint acc;
      drive_beat_type res;
      res = '0;
      if (it.op == pidc_pkg::OP_CLEAR) begin
         held_error = 0;
         integral = 0;
         return res;
      end
      err = longint'($signed(it.error_sample));
      dt = longint'(it.step_time);
      integral = integral + err * dt;
      if (integral > pidc_pkg::IntegMax) begin
         integral = pidc_pkg::IntegMax;
      end else if (integral < pidc_pkg::IntegMin) begin
         integral = pidc_pkg::IntegMin;
      end
      deriv = (dt == 0) ? 0 : ((err - held_error) * 1024) / dt;
      held_error = err;
      acc = longint'(kp) * err * 1024 + longint'(ki) * integral
          + longint'(kd) * deriv * 1024;
      if (acc > pidc_pkg::UnitOne) begin
         res.drive = pidc_pkg::DrivePos;
         res.clamped = 1'b1;
      end else if (acc < pidc_pkg::UnitOneNeg) begin
         res.drive = pidc_pkg::DriveNeg;
         res.clamped = 1'b1;
      end else begin
         res.drive = acc[pidc_pkg::DriveW+15:16];
      end
      return res;
   endfunction

   function automatic void queue_item(pidc_pkg::pidc_op_type op, int err, int dt);
      pidc_pkg::pidc_item_type it;
      it.op = op;
      it.error_sample = pidc_pkg::ErrW'(err);
      it.step_time = pidc_pkg::TimeW'(dt);
      pending_items.push_back(it);
   endfunction

   function automatic pidc_pkg::pidc_item_type rand_item();
      pidc_pkg::pidc_item_type it;
      int pick;
      if ($urandom_range(0, 15) == 0) begin
         it.op = pidc_pkg::OP_CLEAR;
      end else begin
         it.op = pidc_pkg::OP_STEP;
      end
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         it.error_sample = pidc_pkg::ErrW'($urandom);
      end else if (pick < 6) begin
         it.error_sample = pidc_pkg::ErrW'(int'($urandom_range(0, 8192)) - 4096);
      end else begin
         it.error_sample = pidc_pkg::ErrW'(int'($urandom_range(0, 512)) - 256);
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         it.step_time = '0;
      end else if (pick < 9) begin
         it.step_time = pidc_pkg::TimeW'($urandom_range(1, 64));
      end else begin
         it.step_time = pidc_pkg::TimeW'($urandom);
      end
      return it;
   endfunction

   function automatic logic signed [pidc_pkg::GainW-1:0] rand_gain(int bound);
      if ($urandom_range(0, 3) == 0) begin
         return pidc_pkg::GainW'($urandom);
      end
      return pidc_pkg::GainW'(int'($urandom_range(0, 2 * bound)) - bound);
   endfunction

   task automatic write_gain(logic [pidc_pkg::CsrIndexW-1:0] idx,
                             logic signed [pidc_pkg::GainW-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         pidc_pkg::CSR_GAIN_P: kp = value;
         pidc_pkg::CSR_GAIN_I: ki = value;
         pidc_pkg::CSR_GAIN_D: kd = value;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_gains(logic signed [pidc_pkg::GainW-1:0] p,
                            logic signed [pidc_pkg::GainW-1:0] i,
                            logic signed [pidc_pkg::GainW-1:0] d);
      write_gain(pidc_pkg::CSR_GAIN_P, p);
      write_gain(pidc_pkg::CSR_GAIN_I, i);
      write_gain(pidc_pkg::CSR_GAIN_D, d);
   endtask

   task automatic wait_idle(int settle);
      while (pending_items.size() > 0 || expected_drives.size() > 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   initial begin
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      gap_max = 3;

      // Proportional path alone, around both clamp limits.
      queue_item(pidc_pkg::OP_STEP, 0, 0);
      queue_item(pidc_pkg::OP_STEP, 4096, 1024);
      queue_item(pidc_pkg::OP_STEP, 4097, 1024);
      queue_item(pidc_pkg::OP_STEP, -4096, 1024);
      queue_item(pidc_pkg::OP_STEP, -4097, 1024);
      queue_item(pidc_pkg::OP_STEP, 32767, 65535);
      queue_item(pidc_pkg::OP_STEP, -32768, 65535);
      queue_item(pidc_pkg::OP_STEP, 1, 0);
      queue_item(pidc_pkg::OP_STEP, -1, 1);
      queue_item(pidc_pkg::OP_CLEAR, 32767, 65535);
      queue_item(pidc_pkg::OP_STEP, 2048, 0);
      wait_idle(SettleCycles);

      write_gain(CsrUnused, 16'hFFFF);
      set_gains(16'sd16, 16'sd64, 16'sd256);
      queue_item(pidc_pkg::OP_STEP, 1000, 1);
      queue_item(pidc_pkg::OP_STEP, -1000, 3);
      queue_item(pidc_pkg::OP_STEP, -999, 0);
      queue_item(pidc_pkg::OP_STEP, 32767, 65535);
      queue_item(pidc_pkg::OP_STEP, -32768, 65535);
      queue_item(pidc_pkg::OP_CLEAR, -32768, 0);
      queue_item(pidc_pkg::OP_STEP, 5, 7);
      queue_item(pidc_pkg::OP_STEP, -7, 65535);
      wait_idle(SettleCycles);

      for (int ph = 0; ph < RandomPhases; ph++) begin
         case (ph)
            0: set_gains(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
            1: set_gains(16'sh8000, 16'sh8000, 16'sh8000);
            2: set_gains(pidc_pkg::GainZero, pidc_pkg::GainZero, pidc_pkg::GainZero);
            default: set_gains(rand_gain(600), rand_gain(12), rand_gain(400));
         endcase
         gap_max = (ph % 3 == 2) ? 0 : $urandom_range(2, 12);
         repeat (PhaseItems) pending_items.push_back(rand_item());
         wait_idle(SettleCycles);
      end

      wait_idle(DrainCycles);
      if (mismatches == 0 && expected_drives.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_drives.push_back(pid_step(pending_items.pop_front()));
            accepted_items++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= {pending_items[0].step_time, pending_items[0].error_sample};
               req_tuser <= pending_items[0].op;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // The two long holds land mid-phase so the sender keeps offering beats.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (holds_done < 2 && accepted_items >= 500 + holds_done * 800) begin
            hold_left = HoldCycles;
            holds_done++;
         end
         if (mode_left == 0) begin
            ready_pattern = ready_pattern_type'($urandom_range(0, 3));
            mode_left = $urandom_range(32, 400);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (ready_pattern)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_HALF:   rsp_tready <= $urandom_range(0, 1);
               READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:      rsp_tready <= (mode_left % 16) < 11;
            endcase
         end
      end
   end

   always @(posedge clock) begin : result_check
      drive_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_drives.size() == 0) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
               $display("unexpected result beat: drive %0d clamped %0d",
                        $signed(rsp_tdata), rsp_tuser);
            end
         end else begin
            want = expected_drives.pop_front();
            if (rsp_tdata !== want.drive || rsp_tuser !== want.clamped) begin
               mismatches++;
               if (mismatches <= ReportLimit) begin
                  $display("result mismatch: drive exp %0d got %0d, clamped exp %0d got %0d",
                           want.drive, $signed(rsp_tdata), want.clamped, rsp_tuser);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

endmodule
